// ----- sv/rpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rpm_pkg: shared constants for the RMS / peak-hold level meter
// Register indexes of the configuration port, the width of the hold
// countdown and the depth of the queue between the front and back parts.
// ----------------------------------------------------------------------------
package rpm_pkg;

	// Configuration register index
	localparam int CFG_IDX_BITS = 2;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_AVG_COEFF    = 2'd0;
	localparam cfg_idx_t REG_PEAK_COEFF   = 2'd1;
	localparam cfg_idx_t REG_HOLD_COEFF   = 2'd2;
	localparam cfg_idx_t REG_HOLD_SAMPLES = 2'd3;

	// Hold countdown width, fixed by the hold_samples register
	localparam int HOLD_BITS = 20;

	// Entries in the request queue between front and back
	localparam int QUEUE_DEPTH = 2;

endpackage

// ----- sv/rpm_front.sv -----
// ----------------------------------------------------------------------------
// rpm_front: sample intake
// Accepts samples from the input stream, takes the magnitude, squares it
// into an energy and pushes the energy into the request queue.
// ----------------------------------------------------------------------------
module rpm_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                       s_valid,
	output logic                       s_ready,
	input  logic [SAMPLE_BITS-1:0]     sample_in,
	output logic                       q_push,
	input  logic                       q_full,
	output logic [2*SAMPLE_BITS-2:0]   q_energy
);
	import rpm_pkg::*;

	localparam int EW = 2*SAMPLE_BITS - 1;

	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] square;

	// Magnitude of a two's complement sample; full-scale negative fits unsigned.
	always_comb begin
		if (sample_in[SAMPLE_BITS-1]) begin
			mag = (~sample_in) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
		end else begin
			mag = sample_in;
		end
		square = mag * mag;
	end

	// Space in the queue decides whether a request is taken.
	assign s_ready  = !q_full;
	assign q_push   = s_valid && !q_full;
	assign q_energy = square[EW-1:0];

endmodule

// ----- sv/rpm_queue.sv -----
// ----------------------------------------------------------------------------
// rpm_queue: request queue
// Short first-in first-out buffer that lets the front keep taking samples
// while the back is still working on an earlier one.
// ----------------------------------------------------------------------------
module rpm_queue #(
	parameter int WIDTH = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	import rpm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign full      = (count_q == CNTW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/rpm_back.sv -----
// ----------------------------------------------------------------------------
// rpm_back: energy trackers and level computation
// Pops one energy at a time, updates the average, peak and held energies
// (decays through a shared two-bit-per-cycle multiplier), then takes the
// three square roots one result bit per cycle and presents them on the output.
// ----------------------------------------------------------------------------
module rpm_back #(
	parameter int SAMPLE_BITS     = 16,
	parameter int COEFF_FRAC_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2*SAMPLE_BITS-2:0]   in_energy,
	input  logic [COEFF_FRAC_BITS:0]   avg_coeff,
	input  logic [COEFF_FRAC_BITS:0]   peak_coeff,
	input  logic [COEFF_FRAC_BITS:0]   hold_coeff,
	input  logic [rpm_pkg::HOLD_BITS-1:0] hold_samples,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [SAMPLE_BITS-1:0]     avg_level,
	output logic [SAMPLE_BITS-1:0]     peak_level,
	output logic [SAMPLE_BITS-1:0]     hold_level
);
	import rpm_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int F    = COEFF_FRAC_BITS;
	localparam int EW   = 2*SB - 1;
	localparam int CW   = F + 1;
	localparam int NDIG = (CW + 1) / 2;
	localparam int CPW  = 2*NDIG;
	localparam int AW   = CPW + EW;
	localparam int DIGW = $clog2(NDIG);
	localparam int RCW  = $clog2(SB);
	localparam int RW   = SB + 3;
	localparam int RADW = 2*SB;

	localparam logic [CW-1:0] COEFF_ONE = CW'(1) << F;

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_RINIT = 3'd4;
	localparam logic [2:0] S_ROOT  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	// Tracker select
	localparam logic [1:0] SEL_AVG  = 2'd0;
	localparam logic [1:0] SEL_PEAK = 2'd1;
	localparam logic [1:0] SEL_HELD = 2'd2;

	logic [2:0]           state_q;
	logic [1:0]           sel_q;
	logic [EW-1:0]        sq_q;
	logic [EW-1:0]        avg_q;
	logic [EW-1:0]        peak_q;
	logic [EW-1:0]        held_q;
	logic [HOLD_BITS-1:0] cnt_q;

	logic [EW-1:0]        d_q;
	logic                 down_q;
	logic [CPW-1:0]       coef_q;
	logic [AW-1:0]        acc_q;
	logic [DIGW-1:0]      dig_q;

	logic [RADW-1:0]      rad_q  [3];
	logic [RW-1:0]        rem_q  [3];
	logic [SB-1:0]        root_q [3];
	logic [RCW-1:0]       rcnt_q;

	logic                 out_valid_q;
	logic [SB-1:0]        avg_level_q;
	logic [SB-1:0]        peak_level_q;
	logic [SB-1:0]        hold_level_q;

	logic [EW-1:0]        e_cur;
	logic [CW-1:0]        c_raw;
	logic [CW-1:0]        c_eff;
	logic                 need_step;
	logic                 down;
	logic [EW-1:0]        diff;
	logic [1:0]           digit;
	logic [AW-1:0]        part;
	logic [EW-1:0]        q_step;
	logic                 round_up;
	logic [EW-1:0]        e_new;
	logic [RW-1:0]        rem_sh [3];
	logic [RW-1:0]        trial  [3];

	// Selected tracker, its coefficient clamped to one, and the step decision.
	always_comb begin
		case (sel_q)
			SEL_AVG: begin
				e_cur     = avg_q;
				c_raw     = avg_coeff;
				need_step = 1'b1;
			end
			SEL_PEAK: begin
				e_cur     = peak_q;
				c_raw     = peak_coeff;
				need_step = (peak_q > sq_q);
			end
			default: begin
				e_cur     = held_q;
				c_raw     = hold_coeff;
				need_step = !(held_q < sq_q) && (cnt_q == '0);
			end
		endcase
		c_eff = (c_raw > COEFF_ONE) ? COEFF_ONE : c_raw;
		down  = (e_cur > sq_q);
		diff  = down ? (e_cur - sq_q) : (sq_q - e_cur);
	end

	// Shift-add multiplier digit and the step: truncated when rising, rounded up in magnitude when falling.
	always_comb begin
		digit = coef_q[CPW-1 -: 2];
		part  = (digit[0] ? AW'(d_q) : '0) + (digit[1] ? (AW'(d_q) << 1) : '0);
		round_up = down_q && (acc_q[F-1:0] != '0);
		q_step   = acc_q[F +: EW] + EW'(round_up);
		e_new    = down_q ? (e_cur - q_step) : (e_cur + q_step);
	end

	// Square root lanes: bring down two radicand bits and try the next root bit.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_sh[i] = {rem_q[i][RW-3:0], rad_q[i][RADW-1 -: 2]};
			trial[i]  = RW'({root_q[i], 2'b01});
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign avg_level  = avg_level_q;
	assign peak_level = peak_level_q;
	assign hold_level = hold_level_q;

	// Sequencer and tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= SEL_AVG;
			avg_q       <= '0;
			peak_q      <= '0;
			held_q      <= '0;
			cnt_q       <= '0;
			dig_q       <= '0;
			rcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken result clears the output unless a new one replaces it.
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sel_q   <= SEL_AVG;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (need_step) begin
						dig_q   <= DIGW'(NDIG - 1);
						state_q <= S_MUL;
					end else begin
						if (sel_q == SEL_PEAK) begin
							peak_q <= sq_q;
						end else if (held_q < sq_q) begin
							held_q <= sq_q;
							cnt_q  <= hold_samples;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
						if (sel_q == SEL_HELD) begin
							state_q <= S_RINIT;
						end else begin
							sel_q <= sel_q + 1'b1;
						end
					end
				end
				S_MUL: begin
					if (dig_q == '0) begin
						state_q <= S_APPLY;
					end else begin
						dig_q <= dig_q - 1'b1;
					end
				end
				S_APPLY: begin
					case (sel_q)
						SEL_AVG:  avg_q  <= e_new;
						SEL_PEAK: peak_q <= e_new;
						default:  held_q <= e_new;
					endcase
					if (sel_q == SEL_HELD) begin
						state_q <= S_RINIT;
					end else begin
						sel_q   <= sel_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_RINIT: begin
					rcnt_q  <= RCW'(SB - 1);
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (rcnt_q == '0) begin
						state_q <= S_OUT;
					end else begin
						rcnt_q <= rcnt_q - 1'b1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the multiplier, root lanes and result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					sq_q <= in_energy;
				end
			end
			S_LOAD: begin
				d_q    <= diff;
				down_q <= down;
				coef_q <= CPW'(c_eff);
				acc_q  <= '0;
			end
			S_MUL: begin
				acc_q  <= {acc_q[AW-3:0], 2'b00} + part;
				coef_q <= {coef_q[CPW-3:0], 2'b00};
			end
			S_RINIT: begin
				rad_q[0] <= RADW'(avg_q);
				rad_q[1] <= RADW'(peak_q);
				rad_q[2] <= RADW'(held_q);
				for (int i = 0; i < 3; i++) begin
					rem_q[i]  <= '0;
					root_q[i] <= '0;
				end
			end
			S_ROOT: begin
				for (int i = 0; i < 3; i++) begin
					rad_q[i] <= {rad_q[i][RADW-3:0], 2'b00};
					if (rem_sh[i] >= trial[i]) begin
						rem_q[i]  <= rem_sh[i] - trial[i];
						root_q[i] <= {root_q[i][SB-2:0], 1'b1};
					end else begin
						rem_q[i]  <= rem_sh[i];
						root_q[i] <= {root_q[i][SB-2:0], 1'b0};
					end
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					avg_level_q  <= root_q[0];
					peak_level_q <= root_q[1];
					hold_level_q <= root_q[2];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/rms_peak_hold_level_meter.sv -----
// ----------------------------------------------------------------------------
// rms_peak_hold_level_meter: RMS, peak and peak-hold audio level meter
// Squares each signed sample and reports the square roots of a smoothed
// average energy, a decaying peak energy and a held peak energy.
// ----------------------------------------------------------------------------
// Each sample request yields one result request carrying avg_level,
// peak_level and hold_level. A sample spends less time in the back end
// when the peak or held tracker jumps or counts instead of decaying. The
// back-end time is set by the shared multiplier, which retires two
// coefficient bits per cycle for each of the three trackers in turn, and
// by the square root lanes, which produce one level bit per cycle. A
// two-entry queue in front takes new samples while the back end works,
// and the output register holds a finished result until it is taken.
// Coefficients are unsigned fixed point with COEFF_FRAC_BITS fraction
// bits; values above one act as exactly one.
module rms_peak_hold_level_meter #(
	parameter int SAMPLE_BITS     = 16,
	parameter int COEFF_FRAC_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Sample stream; tdata: sample_in
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
	// Level stream; tdata: avg_level, peak_level, hold_level
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
	// Register write port
	input  logic                                   cfg_wr_en,
	input  logic [rpm_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [((COEFF_FRAC_BITS+1 > rpm_pkg::HOLD_BITS) ?
		(COEFF_FRAC_BITS+1) : rpm_pkg::HOLD_BITS)-1:0] cfg_wdata
);
	import rpm_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int CW = COEFF_FRAC_BITS + 1;
	localparam int EW = 2*SB - 1;

	localparam logic [CW-1:0]        AVG_COEFF_RST  = CW'(874);
	localparam logic [CW-1:0]        PEAK_COEFF_RST = CW'(874);
	localparam logic [CW-1:0]        HOLD_COEFF_RST = CW'(87);
	localparam logic [HOLD_BITS-1:0] HOLD_SAMP_RST  = HOLD_BITS'(48000);

	logic [CW-1:0]        avg_coeff_q;
	logic [CW-1:0]        peak_coeff_q;
	logic [CW-1:0]        hold_coeff_q;
	logic [HOLD_BITS-1:0] hold_samples_q;

	logic                 q_push;
	logic                 q_full;
	logic [EW-1:0]        q_in_energy;
	logic                 q_not_empty;
	logic                 q_pop;
	logic [EW-1:0]        q_out_energy;
	logic                 back_ready;
	logic [SB-1:0]        avg_level;
	logic [SB-1:0]        peak_level;
	logic [SB-1:0]        hold_level;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_coeff_q    <= AVG_COEFF_RST;
			peak_coeff_q   <= PEAK_COEFF_RST;
			hold_coeff_q   <= HOLD_COEFF_RST;
			hold_samples_q <= HOLD_SAMP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_AVG_COEFF:    avg_coeff_q    <= cfg_wdata[CW-1:0];
				REG_PEAK_COEFF:   peak_coeff_q   <= cfg_wdata[CW-1:0];
				REG_HOLD_COEFF:   hold_coeff_q   <= cfg_wdata[CW-1:0];
				REG_HOLD_SAMPLES: hold_samples_q <= cfg_wdata[HOLD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sample intake.
	rpm_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.sample_in (s_axis_tdata[SB-1:0]),
		.q_push    (q_push),
		.q_full    (q_full),
		.q_energy  (q_in_energy)
	);

	// Queue between intake and trackers.
	rpm_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in_energy),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_out_energy)
	);

	assign q_pop = q_not_empty && back_ready;

	// Energy trackers and square roots.
	rpm_back #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.COEFF_FRAC_BITS (COEFF_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (q_not_empty),
		.in_ready     (back_ready),
		.in_energy    (q_out_energy),
		.avg_coeff    (avg_coeff_q),
		.peak_coeff   (peak_coeff_q),
		.hold_coeff   (hold_coeff_q),
		.hold_samples (hold_samples_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.avg_level    (avg_level),
		.peak_level   (peak_level),
		.hold_level   (hold_level)
	);

	// Pack the three levels, lowest field first.
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[3*SB-1:0] = {hold_level, peak_level, avg_level};
	end

`ifndef SYNTHESIS
	// A square root of an energy never exceeds full-scale magnitude.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (avg_level <= (SB'(1) << (SB-1))) &&
			(peak_level <= (SB'(1) << (SB-1))) &&
			(hold_level <= (SB'(1) << (SB-1))))
		else $error("level above full scale");

	// No result is offered in the first cycle after reset is released.
	a_no_result_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !m_axis_tvalid)
		else $error("result offered right after reset");

	// A full queue must hold off the sample stream.
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("push into a full queue");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RMS / peak-hold level meter
// Sends signed samples over the sample stream, predicts the average, peak and
// held levels of every request in a bit-exact software copy of the meter, and
// compares each level request against the oldest prediction. Test phases
// cover the sample extremes, zero hold, coefficient extremes and clamping,
// output back-pressure and a stream with no idle cycles.
// ----------------------------------------------------------------------------
module testbench;
	import rpm_pkg::*;

	localparam logic [24:0] COEFF_ONE = 25'h100_0000;
	localparam logic [24:0] COEFF_MAX = 25'h1FF_FFFF;

	// Samples at and near the field extremes, sign flips of equal magnitude
	// and repeats that leave the held energy equal to the square.
	localparam logic [15:0] EDGE_SAMPLES [18] = '{
		16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h0001, 16'hFFFF,
		16'h7FFF, 16'h8001, 16'h8001, 16'h0000, 16'h5555, 16'hAAAA,
		16'h00FF, 16'hFF00, 16'h4000, 16'hC000, 16'h0000, 16'h0000
	};

	// One level request, laid out as on m_axis_tdata (avg in the low bits)
	typedef struct packed {
		logic [15:0] hold;
		logic [15:0] peak;
		logic [15:0] avg;
	} levels_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        cfg_wr_en     = 1'b0;
	cfg_idx_t    cfg_index     = REG_AVG_COEFF;
	logic [24:0] cfg_wdata     = '0;

	levels_t     level_q [$];
	int          error_count   = 0;
	int          stall_cycles  = 0;
	bit          idle_on       = 1'b1;
	logic [15:0] prev_sample   = '0;

	// Software copy of the meter: settings and energy trackers
	logic [24:0]          avg_coeff_r  = 25'd874;
	logic [24:0]          peak_coeff_r = 25'd874;
	logic [24:0]          hold_coeff_r = 25'd87;
	logic [HOLD_BITS-1:0] hold_len_r   = 20'd48000;
	logic [HOLD_BITS-1:0] hold_cnt     = '0;
	logic [30:0]          avg_e        = '0;
	logic [30:0]          peak_e       = '0;
	logic [30:0]          held_e       = '0;

	rms_peak_hold_level_meter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Move an energy toward a target by coefficient / 2^24. The step is
	// floored, so a downward step rounds its magnitude up.
	function automatic logic [30:0] approach(input logic [30:0] e, input logic [24:0] c,
			input logic [30:0] s);
		logic [63:0] coeff;
		logic [63:0] diff;
		logic [63:0] prod;
		coeff = (c > COEFF_ONE) ? 64'(COEFF_ONE) : 64'(c);
		if (s >= e) begin
			diff = s - e;
			prod = coeff * diff;
			return 31'(64'(e) + (prod >> 24));
		end
		diff = e - s;
		prod = coeff * diff;
		return 31'(64'(e) - ((prod + 64'hFF_FFFF) >> 24));
	endfunction

	// Floor of the square root, one result bit at a time from the top.
	function automatic logic [15:0] floor_sqrt(input logic [30:0] v);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int i = 15; i >= 0; i--) begin
			trial = root | (32'd1 << i);
			if (trial * trial <= {1'b0, v})
				root = trial;
		end
		return root[15:0];
	endfunction

	// Advance the trackers by one sample and return the expected levels.
	function automatic levels_t track_levels(input logic [15:0] sample);
		logic signed [16:0] wide;
		logic [16:0]        mag;
		logic [30:0]        sq;
		levels_t            lv;
		wide = $signed(sample);
		mag  = wide[16] ? 17'(-wide) : 17'(wide);
		sq   = mag * mag;

		avg_e = approach(avg_e, avg_coeff_r, sq);

		if (peak_e > sq)
			peak_e = approach(peak_e, peak_coeff_r, sq);
		else
			peak_e = sq;

		if (held_e < sq) begin
			held_e   = sq;
			hold_cnt = hold_len_r;
		end else if (hold_cnt != '0) begin
			hold_cnt = hold_cnt - 1'b1;
		end else begin
			held_e = approach(held_e, hold_coeff_r, sq);
		end

		lv.avg  = floor_sqrt(avg_e);
		lv.peak = floor_sqrt(peak_e);
		lv.hold = floor_sqrt(held_e);
		return lv;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Compare every accepted level request with the oldest prediction.
	always @(posedge clk) begin
		levels_t got;
		levels_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (level_q.size() == 0) begin
				report_mismatch($sformatf("unexpected level request %h", got));
			end else begin
				want = level_q.pop_front();
				if (got.avg !== want.avg)
					report_mismatch($sformatf("avg_level %0d, expected %0d", got.avg, want.avg));
				if (got.peak !== want.peak)
					report_mismatch($sformatf("peak_level %0d, expected %0d", got.peak, want.peak));
				if (got.hold !== want.hold)
					report_mismatch($sformatf("hold_level %0d, expected %0d", got.hold, want.hold));
			end
		end
	end

	// Result side ready: random short idles, plus a long hold-off on request.
	initial begin : drive_result_ready
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (stall_cycles > 0) begin
				n            = stall_cycles;
				stall_cycles = 0;
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 99) < 2) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Offer one sample request, with an optional idle gap before it, and
	// record its prediction once it is taken.
	task automatic send_sample(input logic [15:0] sample);
		int gap;
		if (idle_on && $urandom_range(0, 99) < 14) begin
			gap = $urandom_range(1, 130);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sample;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		level_q.push_back(track_levels(sample));
		prev_sample = sample;
	endtask

	// Register write; only called while the meter is idle.
	task automatic write_reg(input cfg_idx_t idx, input logic [24:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_AVG_COEFF:    avg_coeff_r  = value;
			REG_PEAK_COEFF:   peak_coeff_r = value;
			REG_HOLD_COEFF:   hold_coeff_r = value;
			REG_HOLD_SAMPLES: hold_len_r   = value[HOLD_BITS-1:0];
			default: ;
		endcase
	endtask

	// Stop offering samples and wait for every predicted level request.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (level_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Coefficient choice weighted toward zero, one, one-LSB and the clamp.
	function automatic logic [24:0] pick_coeff();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 25'd1;
			2:       return COEFF_ONE;
			3:       return COEFF_MAX;
			4:       return 25'($urandom_range(32'h100_0001, 32'h1FF_FFFF));
			default: return 25'($urandom_range(0, 32'h100_0000));
		endcase
	endfunction

	// Random program: runs of full-scale noise, loud bursts, quiet
	// stretches and decaying tones, so every tracker jumps, holds and decays.
	task automatic send_program(input int count);
		int          n;
		int          len;
		int          regime;
		int          amp;
		int          mag;
		logic [15:0] s;
		n = 0;
		while (n < count) begin
			regime = $urandom_range(0, 3);
			len    = $urandom_range(1, 40);
			amp    = $urandom_range(1000, 32767);
			for (int k = 0; k < len && n < count; k++) begin
				if ($urandom_range(0, 99) < 8) begin
					s = prev_sample;
				end else begin
					case (regime)
						0: s = 16'($urandom);
						1: begin
							mag = $urandom_range(28000, 32768);
							s   = $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
						end
						2: s = 16'(int'($urandom_range(0, 512)) - 256);
						default: begin
							s   = $urandom_range(0, 1) ? 16'(amp) : 16'(-amp);
							amp = amp - amp / 8;
						end
					endcase
				end
				send_sample(s);
				n++;
			end
		end
	endtask

	// Reset settings against the extremes and sign flips of the sample.
	task automatic test_edge_samples();
		foreach (EDGE_SAMPLES[i])
			send_sample(EDGE_SAMPLES[i]);
		wait_idle();
	endtask

	// Zero hold with a unit decay: the held level follows the square of each
	// item. The hold write also carries junk above the 20-bit field.
	task automatic test_zero_hold();
		write_reg(REG_HOLD_SAMPLES, 25'h1F0_0000);
		write_reg(REG_HOLD_COEFF, COEFF_ONE);
		write_reg(REG_AVG_COEFF, '0);
		write_reg(REG_PEAK_COEFF, COEFF_MAX);
		send_sample(16'h7FFF);
		send_sample(16'h0000);
		send_sample(16'h0000);
		send_sample(16'h8000);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_program(150);
		wait_idle();
	endtask

	// Several settings: all zero with the longest hold, all at the clamp with
	// a one-sample hold, then random mixes with mostly short holds.
	task automatic test_setting_sweep();
		logic [24:0] hold_word;
		for (int p = 0; p < 7; p++) begin
			if (p == 0) begin
				write_reg(REG_AVG_COEFF, '0);
				write_reg(REG_PEAK_COEFF, '0);
				write_reg(REG_HOLD_COEFF, '0);
				write_reg(REG_HOLD_SAMPLES, 25'h00F_FFFF);
			end else if (p == 1) begin
				write_reg(REG_AVG_COEFF, COEFF_MAX);
				write_reg(REG_PEAK_COEFF, COEFF_MAX);
				write_reg(REG_HOLD_COEFF, COEFF_MAX);
				write_reg(REG_HOLD_SAMPLES, 25'd1);
			end else begin
				hold_word = 25'($urandom);
				if ($urandom_range(0, 3) != 0)
					hold_word[19:0] = 20'($urandom_range(0, 40));
				write_reg(REG_AVG_COEFF, pick_coeff());
				write_reg(REG_PEAK_COEFF, pick_coeff());
				write_reg(REG_HOLD_COEFF, pick_coeff());
				write_reg(REG_HOLD_SAMPLES, hold_word);
			end
			send_program(170);
			wait_idle();
		end
	endtask

	// Long result hold-off while samples keep coming, so the input stalls.
	task automatic test_output_stall();
		write_reg(REG_HOLD_SAMPLES, 25'd5);
		stall_cycles = 1500;
		send_program(40);
		wait_idle();
	endtask

	// Back-to-back requests on both sides with no idle cycles.
	task automatic test_steady_stream();
		idle_on = 1'b0;
		write_reg(REG_AVG_COEFF, 25'h020_0000);
		write_reg(REG_HOLD_COEFF, 25'h008_0000);
		send_program(200);
		wait_idle();
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_samples();
		test_zero_hold();
		test_setting_sweep();
		test_output_stall();
		test_steady_stream();
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
